// ----- src/cdd_pkg.sv -----
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared types, constants and codes for the contour distance decimator.
// ----------------------------------------------------------------------------
package cdd_pkg;

  // default geometry
  localparam int COORD_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF   = 24;

  // configuration registers
  localparam int THRESH_WIDTH    = 17;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 17'd16;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_MODE      = 2'd0,
    CFG_THRESHOLD = 2'd1
  } cfg_index_t;

  typedef enum logic {
    MODE_ANCHOR = 1'b0,
    MODE_PATH   = 1'b1
  } mode_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_THR,
    ST_SUM,
    ST_CMP,
    ST_ROOT,
    ST_ACC,
    ST_EMIT
  } state_t;

  // shared multiplier operand select
  typedef enum logic [1:0] {
    MUL_DX,
    MUL_DY,
    MUL_THR
  } mul_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     diff;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum;
    logic     cmp;
    logic     root_step;
    logic     acc;
    logic     commit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic start;
    logic path_mode;
    logic root_last;
    logic out_free;
    logic keep;
  } dp_sts_t;

endpackage

// ----- src/cdd_point_if.sv -----
// ----------------------------------------------------------------------------
// cdd_point_if
// Point channel: coordinates and contour framing flags.
// ----------------------------------------------------------------------------
interface cdd_point_if #(
  parameter int W = cdd_pkg::COORD_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] x;
  logic signed [W-1:0] y;
  logic                contour_start;
  logic                contour_end;

  modport source (output valid, x, y, contour_start, contour_end, input ready);
  modport sink   (input valid, x, y, contour_start, contour_end, output ready);
endinterface

// ----- src/cdd_result_if.sv -----
// ----------------------------------------------------------------------------
// cdd_result_if
// Result channel: keep decision, point copy and end marker.
// ----------------------------------------------------------------------------
interface cdd_result_if #(
  parameter int W = cdd_pkg::COORD_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic                keep;
  logic signed [W-1:0] out_x;
  logic signed [W-1:0] out_y;
  logic                end_mark;

  modport source (output valid, keep, out_x, out_y, end_mark, input ready);
  modport sink   (input valid, keep, out_x, out_y, end_mark, output ready);
endinterface

// ----- src/cdd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// cdd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cdd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cdd_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [cdd_pkg::THRESH_WIDTH-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/cdd_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdd_ctrl
// Sequencer for one point: difference, squares, sum, then compare or root and accumulate.
// ----------------------------------------------------------------------------
module cdd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cdd_pkg::dp_sts_t sts,
  output cdd_pkg::dp_cmd_t cmd,
  output cdd_pkg::state_t  state_out
);

  cdd_pkg::state_t state;
  cdd_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.mul_sel   = cdd_pkg::MUL_DX;
    in_ready      = 1'b0;
    case (state)
      cdd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = cdd_pkg::ST_DIFF;
        end
      end
      cdd_pkg::ST_DIFF: begin
        if (sts.start) begin
          state_next = cdd_pkg::ST_EMIT;
        end else begin
          cmd.diff   = 1'b1;
          state_next = cdd_pkg::ST_SQX;
        end
      end
      cdd_pkg::ST_SQX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cdd_pkg::MUL_DX;
        state_next  = cdd_pkg::ST_SQY;
      end
      cdd_pkg::ST_SQY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cdd_pkg::MUL_DY;
        state_next  = cdd_pkg::ST_THR;
      end
      cdd_pkg::ST_THR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cdd_pkg::MUL_THR;
        state_next  = cdd_pkg::ST_SUM;
      end
      cdd_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = sts.path_mode ? cdd_pkg::ST_ROOT : cdd_pkg::ST_CMP;
      end
      cdd_pkg::ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = cdd_pkg::ST_EMIT;
      end
      cdd_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_next = cdd_pkg::ST_ACC;
        end
      end
      cdd_pkg::ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = cdd_pkg::ST_EMIT;
      end
      cdd_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = cdd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cdd_pkg::ST_IDLE;
      end
    endcase
  end

  assign state_out = state;

endmodule

// ----- src/cdd_dp.sv -----
// ----------------------------------------------------------------------------
// cdd_dp
// Datapath: config registers, point state, shared squarer, bit-serial root,
// path accumulator and the output register.
// ----------------------------------------------------------------------------
module cdd_dp #(
  parameter int COORD_WIDTH = cdd_pkg::COORD_WIDTH_DEF,
  parameter int SUM_WIDTH   = cdd_pkg::SUM_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cdd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [cdd_pkg::THRESH_WIDTH-1:0]    cfg_data,
  // point input
  input  logic signed [COORD_WIDTH-1:0]       in_x,
  input  logic signed [COORD_WIDTH-1:0]       in_y,
  input  logic                                in_start,
  input  logic                                in_end,
  // result output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_keep,
  output logic signed [COORD_WIDTH-1:0]       out_x,
  output logic signed [COORD_WIDTH-1:0]       out_y,
  output logic                                out_end,
  // controller link
  input  cdd_pkg::dp_cmd_t                    cmd,
  output cdd_pkg::dp_sts_t                    sts
);

  localparam int CW   = COORD_WIDTH;
  localparam int SW   = SUM_WIDTH;
  localparam int TW   = cdd_pkg::THRESH_WIDTH;
  localparam int DIFW = CW + 1;
  localparam int MOPW = (DIFW > TW) ? DIFW : TW;
  localparam int PW   = 2 * MOPW;
  localparam int SQW  = 2 * DIFW;
  localparam int D2W  = (SQW > 64) ? 64 : SQW;
  localparam int RW   = D2W / 2;
  localparam int CMPW = (D2W > PW) ? D2W : PW;
  localparam int ACW  = ((SW > RW) ? SW : RW) + 1;
  localparam int CNTW = $clog2(RW);
  localparam logic [CNTW-1:0] ROOT_LAST = CNTW'(RW - 1);

  // configuration
  logic          mode;
  logic [TW-1:0] threshold;

  // latched input point
  logic signed [CW-1:0] pt_x;
  logic signed [CW-1:0] pt_y;
  logic                 pt_start;
  logic                 pt_end;

  // contour state
  logic signed [CW-1:0] anchor_x;
  logic signed [CW-1:0] anchor_y;
  logic signed [CW-1:0] prev_x;
  logic signed [CW-1:0] prev_y;
  logic [SW-1:0]        path_sum;
  logic [SW-1:0]        sum_new;
  logic                 keep;

  // arithmetic registers
  logic [DIFW-1:0]   adx;
  logic [DIFW-1:0]   ady;
  logic [SQW-1:0]    sq_x;
  logic [SQW-1:0]    sq_y;
  logic [2*TW-1:0]   thr_sq;
  logic [D2W-1:0]    d2;
  logic [D2W-1:0]    rad;
  logic [RW+1:0]     rem;
  logic [RW-1:0]     root;
  logic [CNTW-1:0]   cnt;

  // combinational terms
  logic signed [CW-1:0] ref_x;
  logic signed [CW-1:0] ref_y;
  logic [DIFW-1:0]      dx;
  logic [DIFW-1:0]      dy;
  logic [MOPW-1:0]      mul_op;
  logic [PW-1:0]        prod;
  logic [SQW-1:0]       dsum;
  logic [D2W-1:0]       d2_sat;
  logic [RW+1:0]        rem_sh;
  logic [RW+1:0]        trial;
  logic [ACW-1:0]       acc_sum;
  logic [ACW-1:0]       acc_sat;
  logic [ACW-1:0]       sum_max;

  // configuration write, always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= cdd_pkg::MODE_ANCHOR;
      threshold <= cdd_pkg::THRESH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        cdd_pkg::CFG_MODE:      mode      <= cfg_data[0];
        cdd_pkg::CFG_THRESHOLD: threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // difference against anchor or previous point, magnitude only
  assign ref_x = (mode == cdd_pkg::MODE_PATH) ? prev_x : anchor_x;
  assign ref_y = (mode == cdd_pkg::MODE_PATH) ? prev_y : anchor_y;
  assign dx = {pt_x[CW-1], pt_x} - {ref_x[CW-1], ref_x};
  assign dy = {pt_y[CW-1], pt_y} - {ref_y[CW-1], ref_y};

  // shared squarer
  always_comb begin
    case (cmd.mul_sel)
      cdd_pkg::MUL_DX:  mul_op = MOPW'(adx);
      cdd_pkg::MUL_DY:  mul_op = MOPW'(ady);
      cdd_pkg::MUL_THR: mul_op = MOPW'(threshold);
      default:          mul_op = '0;
    endcase
  end
  assign prod = PW'(mul_op) * PW'(mul_op);

  // squared distance, saturated to 64 bits for the widest coordinates
  assign dsum = sq_x + sq_y;
  generate
    if (SQW > 64) begin : g_sat
      assign d2_sat = (|dsum[SQW-1:64]) ? {D2W{1'b1}} : dsum[63:0];
    end else begin : g_nosat
      assign d2_sat = D2W'(dsum);
    end
  endgenerate

  // one root bit per step
  assign rem_sh = {rem[RW-1:0], rad[D2W-1:D2W-2]};
  assign trial  = {root, 2'b01};

  // path accumulation with saturation
  assign sum_max = ACW'({SW{1'b1}});
  assign acc_sum = ACW'(path_sum) + ACW'(root);
  assign acc_sat = (acc_sum > sum_max) ? sum_max : acc_sum;

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt_x     <= in_x;
      pt_y     <= in_y;
      pt_start <= in_start;
      pt_end   <= in_end;
      keep     <= 1'b0;
    end
    if (cmd.diff) begin
      adx <= dx[DIFW-1] ? (~dx + 1'b1) : dx;
      ady <= dy[DIFW-1] ? (~dy + 1'b1) : dy;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        cdd_pkg::MUL_DX:  sq_x   <= SQW'(prod);
        cdd_pkg::MUL_DY:  sq_y   <= SQW'(prod);
        cdd_pkg::MUL_THR: thr_sq <= prod[2*TW-1:0];
        default: begin
        end
      endcase
    end
    if (cmd.sum) begin
      d2   <= d2_sat;
      rad  <= d2_sat;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end
    if (cmd.cmp) begin
      keep <= CMPW'(d2) > CMPW'(thr_sq);
    end
    if (cmd.root_step) begin
      rad <= rad << 2;
      cnt <= cnt + 1'b1;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RW-2:0], 1'b0};
      end
    end
    if (cmd.acc) begin
      if (acc_sat > ACW'(threshold)) begin
        keep    <= 1'b1;
        sum_new <= '0;
      end else begin
        keep    <= 1'b0;
        sum_new <= acc_sat[SW-1:0];
      end
    end
  end

  // contour state update when the result is handed over
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x <= '0;
      anchor_y <= '0;
      prev_x   <= '0;
      prev_y   <= '0;
      path_sum <= '0;
    end else if (cmd.commit) begin
      prev_x <= pt_x;
      prev_y <= pt_y;
      if (pt_start) begin
        anchor_x <= pt_x;
        anchor_y <= pt_y;
        path_sum <= '0;
      end else begin
        if (keep) begin
          anchor_x <= pt_x;
          anchor_y <= pt_y;
        end
        if (mode == cdd_pkg::MODE_PATH) begin
          path_sum <= sum_new;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_keep <= keep;
      out_x    <= pt_x;
      out_y    <= pt_y;
      out_end  <= pt_end;
    end
  end

  // status
  assign sts.start     = pt_start;
  assign sts.path_mode = (mode == cdd_pkg::MODE_PATH);
  assign sts.root_last = (cnt == ROOT_LAST);
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.keep      = keep;

endmodule

// ----- src/contour_distance_decimator.sv -----
// ----------------------------------------------------------------------------
// contour_distance_decimator
// Thins contour points by distance from the last kept point or by path length.
// ----------------------------------------------------------------------------
// One point is worked on at a time and every point gives one result. A start
// point passes the difference state straight to hand-over; an anchor-mode point
// passes difference, the three squares, sum and compare, and a path-mode point
// passes difference, squares, sum, the one-bit-per-cycle square root and the
// accumulate; the three squares share one multiplier. A finished result sits
// in the output register, so a new point is accepted while it waits; the next
// result is held back until the previous one is taken.
module contour_distance_decimator #(
  parameter int COORD_WIDTH = cdd_pkg::COORD_WIDTH_DEF,
  parameter int SUM_WIDTH   = cdd_pkg::SUM_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  cdd_cfg_if.sink      cfg,
  cdd_point_if.sink    pt,
  cdd_result_if.source res
);

  cdd_pkg::dp_cmd_t cmd;
  cdd_pkg::dp_sts_t sts;
  cdd_pkg::state_t  state;
  logic             in_ready;

  // sequencer
  cdd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pt.valid),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd),
    .state_out (state)
  );

  assign pt.ready = in_ready;

  // datapath
  cdd_dp #(
    .COORD_WIDTH (COORD_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .in_x      (pt.x),
    .in_y      (pt.y),
    .in_start  (pt.contour_start),
    .in_end    (pt.contour_end),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_keep  (res.keep),
    .out_x     (res.out_x),
    .out_y     (res.out_y),
    .out_end   (res.end_mark),
    .cmd       (cmd),
    .sts       (sts)
  );

  // an accepted point closes the input until its result is handed over
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    pt.valid && pt.ready |=> !pt.ready)
    else $error("input accepted while a point is in flight");

  // results are only loaded into a free output register
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!res.valid || res.ready))
    else $error("result overwrote one not yet taken");

  // a start point is never kept
  a_start_not_kept: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && sts.start |-> !sts.keep)
    else $error("start point marked as kept");

  // commit only leaves the hand-over state
  a_commit_state: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == cdd_pkg::ST_IDLE)
    else $error("sequencer did not return to idle after hand-over");

endmodule

// ----- sim/tb_contour_distance_decimator.sv -----
// ----------------------------------------------------------------------------
// tb_contour_distance_decimator
// Drives contour points through the decimator in anchor and path mode and
// checks every keep decision, point copy and end marker against a predictor
// that tracks the anchor, previous point and path length.
// ----------------------------------------------------------------------------
module tb_contour_distance_decimator;
  timeunit 1ns;
  timeprecision 1ps;

  import cdd_pkg::*;

  localparam int CW    = COORD_WIDTH_DEF;
  localparam int SW    = SUM_WIDTH_DEF;
  localparam int ITEMS_PER_PHASE = 228;
  localparam int PHASES          = 8;

  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [THRESH_WIDTH-1:0] THRESH_MAX = '1;
  localparam longint unsigned SUM_LIMIT = (64'd1 << SW) - 64'd1;

  // register indexes that the block does not decode
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 contour_start;
    logic                 contour_end;
  } point_t;

  typedef struct packed {
    logic                 keep;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 end_mark;
  } decision_t;

  // predicts keep decisions and holds the decisions still to come
  class decimation_scoreboard;
    mode_t                   mode;
    logic [THRESH_WIDTH-1:0] thr;
    logic signed [CW-1:0]    anc_x, anc_y, prv_x, prv_y;
    logic [SW-1:0]           path_len;
    decision_t               due_decisions[$];
    int unsigned             mismatches;

    function new();
      mode        = MODE_ANCHOR;
      thr         = THRESH_RESET;
      anc_x       = '0;
      anc_y       = '0;
      prv_x       = '0;
      prv_y       = '0;
      path_len    = '0;
      mismatches  = 0;
    endfunction

    function int pending();
      return due_decisions.size();
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [THRESH_WIDTH-1:0] val);
      if (idx == CFG_MODE) begin
        mode = mode_t'(val[0]);
      end else if (idx == CFG_THRESHOLD) begin
        thr = val;
      end
    endfunction

    function longint unsigned sq_dist(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                                      logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
      longint dx;
      longint dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    // one accepted point gives exactly one decision
    function void take_point(point_t p);
      decision_t         d;
      longint unsigned   d2;
      longint unsigned   lim;
      longint unsigned   rem;
      longint unsigned   root;
      longint unsigned   probe;
      longint unsigned   total;
      d.keep = 1'b0;
      if (p.contour_start) begin
        anc_x    = p.x;
        anc_y    = p.y;
        path_len = '0;
      end else if (mode == MODE_ANCHOR) begin
        d2     = sq_dist(p.x, p.y, anc_x, anc_y);
        lim    = 64'(thr);
        d.keep = d2 > lim * lim;
      end else begin
        // floor square root of the squared step length
        rem   = sq_dist(p.x, p.y, prv_x, prv_y);
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem) probe = probe >> 2;
        while (probe != 0) begin
          if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
          end else begin
            root = root >> 1;
          end
          probe = probe >> 2;
        end
        total = longint'(path_len) + root;
        if (total > SUM_LIMIT) total = SUM_LIMIT;
        if (total > thr) begin
          d.keep = 1'b1;
          total  = 0;
        end
        path_len = total[SW-1:0];
      end
      if (d.keep) begin
        anc_x = p.x;
        anc_y = p.y;
      end
      prv_x      = p.x;
      prv_y      = p.y;
      d.x        = p.x;
      d.y        = p.y;
      d.end_mark = p.contour_end;
      due_decisions = {due_decisions, d};
    endfunction

    function void check_result(decision_t got);
      decision_t want;
      if (due_decisions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: keep=%0d x=%0d y=%0d end=%0d",
                   got.keep, got.x, got.y, got.end_mark);
        return;
      end
      want = due_decisions.pop_front();
      if (got.keep !== want.keep || got.x !== want.x || got.y !== want.y ||
          got.end_mark !== want.end_mark) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("result mismatch: expected keep=%0d x=%0d y=%0d end=%0d, ",
                 want.keep, want.x, want.y, want.end_mark);
          $display("got keep=%0d x=%0d y=%0d end=%0d",
                   got.keep, got.x, got.y, got.end_mark);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  cdd_cfg_if                 cfg_bus ();
  cdd_point_if  #(.W(CW))    pt_bus ();
  cdd_result_if #(.W(CW))    res_bus ();

  contour_distance_decimator #(
    .COORD_WIDTH (CW),
    .SUM_WIDTH   (SW)
  ) uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .pt  (pt_bus),
    .res (res_bus)
  );

  decimation_scoreboard sb = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

  // result side: random back-pressure and checking
  always @(posedge clk) begin
    res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && res_bus.valid && res_bus.ready)
      sb.check_result({res_bus.keep, res_bus.out_x, res_bus.out_y, res_bus.end_mark});
  end

  // accepted points and register writes feed the predictor
  always @(posedge clk) begin
    if (!rst && pt_bus.valid && pt_bus.ready)
      sb.take_point({pt_bus.x, pt_bus.y, pt_bus.contour_start, pt_bus.contour_end});
    if (!rst && cfg_bus.valid && cfg_bus.ready)
      sb.write_reg(cfg_bus.index, cfg_bus.data);
  end

  // one register write transaction; valid is left high for a following write
  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [THRESH_WIDTH-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  // one point transaction with random idle cycles ahead of it
  task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic first_pt, logic last_pt);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      pt_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pt_bus.valid         <= 1'b1;
    pt_bus.x             <= x;
    pt_bus.y             <= y;
    pt_bus.contour_start <= first_pt;
    pt_bus.contour_end   <= last_pt;
    @(posedge clk);
    while (!pt_bus.ready) @(posedge clk);
  endtask

  // wait until every decision is back so registers can change
  task automatic drain();
    pt_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // random contours: mostly framed walks, some noise on framing and coordinates
  task automatic send_contours(int unsigned count, logic [THRESH_WIDTH-1:0] thr_now);
    int unsigned          left;
    int unsigned          len;
    int                   span;
    int                   roll;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    left = count;
    cx   = CW'($urandom);
    cy   = CW'($urandom);
    while (left > 0) begin
      len = $urandom_range(1, 24);
      case ($urandom_range(3))
        0:       span = 4;
        1:       span = 64;
        2:       span = 1024;
        default: span = (thr_now / 2 + 1 > 32767) ? 32767 : int'(thr_now) / 2 + 1;
      endcase
      for (int k = 0; k < len && left > 0; k++) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          cx = CW'($urandom);
          cy = CW'($urandom);
        end else if (roll < 8) begin
          cx = $urandom_range(1) ? COORD_MAX : COORD_MIN;
          cy = $urandom_range(1) ? COORD_MAX : COORD_MIN;
        end else begin
          cx = CW'(int'(cx) + int'($urandom_range(0, 2 * span)) - span);
          cy = CW'(int'(cy) + int'($urandom_range(0, 2 * span)) - span);
        end
        if ($urandom_range(99) < 8)
          send_point(cx, cy, 1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          send_point(cx, cy, k == 0, k == len - 1);
        left--;
      end
    end
  endtask

  // main sequence
  initial begin
    logic [THRESH_WIDTH-1:0] thr_now;
    logic [THRESH_WIDTH-1:0] mode_word;
    pt_bus.valid         <= 1'b0;
    pt_bus.x             <= '0;
    pt_bus.y             <= '0;
    pt_bus.contour_start <= 1'b0;
    pt_bus.contour_end   <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= CFG_MODE;
    cfg_bus.data         <= '0;
    rst                  <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // anchor mode at reset threshold, points before any contour start
    send_point(16, 0, 1'b0, 1'b0);
    send_point(0, 17, 1'b0, 1'b0);
    send_point(COORD_MIN, COORD_MIN, 1'b1, 1'b1);
    send_point(COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 1'b0, 1'b1);
    send_point(-1, -1, 1'b1, 1'b0);
    send_point(-1, 15, 1'b0, 1'b1);

    // path mode, zero threshold, mode change with no new contour start
    drain();
    write_reg(CFG_MODE, {16'h5a5a, MODE_PATH});
    write_reg(CFG_THRESHOLD, '0);
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '0);
    cfg_bus.valid <= 1'b0;
    send_point(-1, -1, 1'b0, 1'b0);
    send_point(-1, -1, 1'b0, 1'b0);
    send_point(0, 0, 1'b0, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0, 1'b1);

    // path mode, largest threshold with longest steps
    drain();
    write_reg(CFG_THRESHOLD, THRESH_MAX);
    cfg_bus.valid <= 1'b0;
    send_point(COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    send_point(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0, 1'b1);

    // anchor mode, largest threshold
    drain();
    write_reg(CFG_MODE, {16'h0000, MODE_ANCHOR});
    cfg_bus.valid <= 1'b0;
    send_point(COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    send_point(COORD_MIN, COORD_MAX, 1'b0, 1'b1);

    // random phases over modes, thresholds and idling styles
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        1:       thr_now = '0;
        2:       thr_now = THRESH_MAX;
        default: begin
          case ($urandom_range(3))
            0:       thr_now = THRESH_WIDTH'($urandom_range(1, 100));
            1:       thr_now = THRESH_WIDTH'($urandom_range(100, 3000));
            2:       thr_now = THRESH_RESET;
            default: thr_now = THRESH_WIDTH'($urandom);
          endcase
        end
      endcase
      mode_word    = THRESH_WIDTH'($urandom);
      mode_word[0] = (p[0] ^ p[2]) ? MODE_PATH : MODE_ANCHOR;
      write_reg(CFG_MODE, mode_word);
      write_reg(CFG_THRESHOLD, thr_now);
      if ($urandom_range(1))
        write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  THRESH_WIDTH'($urandom));
      cfg_bus.valid <= 1'b0;
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      send_contours(ITEMS_PER_PHASE, thr_now);
    end

    // let the last decisions come back, then watch for stray results
    drain();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
